// ===== design/date_to_seconds_since_reference_assert.svh =====
// Assertion macros shared by the date to seconds checker.
`ifndef DATE_TO_SECONDS_SINCE_REFERENCE_ASSERT_SVH
`define DATE_TO_SECONDS_SINCE_REFERENCE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define DTSR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("dtsr: invariant violated");

// A consequence that must follow a given number of cycles after a cause.
`define DTSR_ASSERT_DELAY(label, clk, rst_n, cause, n, effect) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cause) |-> ##n (effect)) \
		else $error("dtsr: delayed check failed");

`endif

// ===== design/dtsr_pkg.sv =====
// Types, constants and helper functions of the date to seconds converter.
`default_nettype none

package dtsr_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int OUT_W   = 34;

	// year / 4 and (year / 4) / 25
	localparam int QUOT_W  = YEAR_W - 2;
	localparam int CENT_W  = 6;
	localparam int RECIP_W = 16;
	localparam int RECIP_SHIFT = 10;
	localparam int LEAP_W  = 10;
	localparam int MD_W    = 9;
	localparam int YDAYS_W = 21;
	localparam int DAYS_W  = 22;
	localparam int TOD_W   = 17;
	localparam int SPD_W   = 17;
	localparam int PROD_W  = DAYS_W + SPD_W;

	// floor(q * 41 / 1024) equals floor(q / 25) for every q below 1024.
	localparam logic [RECIP_W-1:0] RECIP_25   = 16'd41;
	localparam logic [QUOT_W-1:0]  CENT_DIV   = 10'd25;
	localparam logic [MD_W-1:0]    DAYS_PER_YEAR = 9'd365;
	localparam logic [SPD_W-1:0]   SECS_PER_DAY  = 17'd86400;
	localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
	localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;
	localparam logic [OUT_W-1:0]   OUT_MAX = {OUT_W{1'b1}};
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_REFERENCE_YEAR = 1'b0;
	localparam logic [YEAR_W-1:0] REFERENCE_YEAR_RST = 12'd1990;

	typedef struct packed {
		logic                vld;
		logic [DAYS_W-1:0]   days;
		logic [TOD_W-1:0]    tod;
	} days_beat_t;

	// Days in the whole months before the given one; codes above twelve count the full year.
	function automatic logic [MD_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
		logic [MD_W-1:0] d;
		unique case (month)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = DAYS_PER_YEAR;
		endcase
		return d;
	endfunction

	// Leap years in 0 .. y-1, given q = (y-1)/4 and c = q/25, for y above zero.
	function automatic logic [LEAP_W-1:0] leap_count(input logic [QUOT_W-1:0] q,
			input logic [CENT_W-1:0] c);
		logic [LEAP_W:0] s;
		s = {1'b0, q} - {{(LEAP_W+1-CENT_W){1'b0}}, c}
			+ {{(LEAP_W+3-CENT_W){1'b0}}, c[CENT_W-1:2]} + 11'd1;
		return s[LEAP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/dtsr_apb.sv =====
// Configuration register file holding the reference year.
`default_nettype none

module dtsr_apb (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [dtsr_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [dtsr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [dtsr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready,
	output logic      [dtsr_pkg::YEAR_W-1:0]         ref_year
);

	logic [dtsr_pkg::YEAR_W-1:0] reference_year_q;
	logic                        reg_sel;

	// Only the word index takes part in decoding; the byte offset is ignored.
	assign reg_sel = (paddr[dtsr_pkg::APB_ADDR_W-1:2] == dtsr_pkg::REG_REFERENCE_YEAR);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_year_q <= dtsr_pkg::REFERENCE_YEAR_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			reference_year_q <= pwdata[dtsr_pkg::YEAR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(dtsr_pkg::APB_DATA_W-dtsr_pkg::YEAR_W){1'b0}}, reference_year_q};
		end
	end

	assign ref_year = reference_year_q;

endmodule

`default_nettype wire

// ===== design/dtsr_days.sv =====
// Day count pipeline: whole years with leap days, months, days and time of day.
`default_nettype none

module dtsr_days (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [dtsr_pkg::YEAR_W-1:0]       year,
	input  wire logic [dtsr_pkg::MONTH_W-1:0]      month,
	input  wire logic [dtsr_pkg::DAY_W-1:0]        day,
	input  wire logic [dtsr_pkg::HOUR_W-1:0]       hour,
	input  wire logic [dtsr_pkg::MIN_W-1:0]        minute,
	input  wire logic [dtsr_pkg::SEC_W-1:0]        second,
	input  wire logic [dtsr_pkg::YEAR_W-1:0]       ref_year,
	output dtsr_pkg::days_beat_t                   beat
);

	localparam int YW = dtsr_pkg::YEAR_W;
	localparam int QW = dtsr_pkg::QUOT_W;
	localparam int CW = dtsr_pkg::CENT_W;
	localparam int RW = dtsr_pkg::RECIP_W;
	localparam int LW = dtsr_pkg::LEAP_W;
	localparam int MW = dtsr_pkg::MD_W;
	localparam int YDW = dtsr_pkg::YDAYS_W;
	localparam int DW = dtsr_pkg::DAYS_W;
	localparam int TW = dtsr_pkg::TOD_W;

	// ---- stage 1: differences, reciprocal products, time of day ----
	logic [YW-1:0] yp, rp, diff;
	logic [QW-1:0] qyp, qy, qrp;
	logic [TW-1:0] tod;

	logic                           vld_s1;
	logic [QW-1:0]                  qyp_s1, qy_s1, qrp_s1;
	logic [RW-1:0]                  pyp_s1, py_s1, prp_s1;
	logic [1:0]                     ylo_s1;
	logic                           yzero_s1, rzero_s1, gt_s1;
	logic [YW-1:0]                  diff_s1;
	logic [dtsr_pkg::MONTH_W-1:0]   month_s1;
	logic [dtsr_pkg::DAY_W-1:0]     day_s1;
	logic [TW-1:0]                  tod_s1;

	assign yp   = year - 12'd1;
	assign rp   = ref_year - 12'd1;
	assign diff = year - ref_year;
	assign qyp  = yp[YW-1:2];
	assign qy   = year[YW-1:2];
	assign qrp  = rp[YW-1:2];
	assign tod  = TW'(hour) * dtsr_pkg::SECS_PER_HOUR + TW'(minute) * dtsr_pkg::SECS_PER_MIN
		+ TW'(second);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		qyp_s1   <= qyp;
		qy_s1    <= qy;
		qrp_s1   <= qrp;
		pyp_s1   <= {{(RW-QW){1'b0}}, qyp} * dtsr_pkg::RECIP_25;
		py_s1    <= {{(RW-QW){1'b0}}, qy} * dtsr_pkg::RECIP_25;
		prp_s1   <= {{(RW-QW){1'b0}}, qrp} * dtsr_pkg::RECIP_25;
		ylo_s1   <= year[1:0];
		yzero_s1 <= (year == '0);
		rzero_s1 <= (ref_year == '0);
		gt_s1    <= (year > ref_year);
		diff_s1  <= diff;
		month_s1 <= month;
		day_s1   <= day;
		tod_s1   <= tod;
	end

	// ---- stage 2: leap counts, leap flag, year days, month and day offset ----
	logic [CW-1:0] c_yp, c_y, c_rp;
	logic          cent, leap, leap_adj;
	logic [dtsr_pkg::DAY_W-1:0] day_off;

	logic           vld_s2;
	logic           gt_s2;
	logic [YDW-1:0] ydays_s2;
	logic [LW-1:0]  leaps_y_s2, leaps_r_s2;
	logic [MW-1:0]  md_s2;
	logic [TW-1:0]  tod_s2;

	assign c_yp = pyp_s1[dtsr_pkg::RECIP_SHIFT +: CW];
	assign c_y  = py_s1[dtsr_pkg::RECIP_SHIFT +: CW];
	assign c_rp = prp_s1[dtsr_pkg::RECIP_SHIFT +: CW];

	// A year divisible by four is a century when its quarter is a multiple of 25.
	assign cent     = (qy_s1 == {{(QW-CW){1'b0}}, c_y} * dtsr_pkg::CENT_DIV);
	assign leap     = (ylo_s1 == 2'd0) && (!cent || (c_y[1:0] == 2'd0));
	assign leap_adj = leap && (month_s1 > dtsr_pkg::MONTH_FEB);
	assign day_off  = (day_s1 != '0) ? day_s1 - 5'd1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		gt_s2      <= gt_s1;
		ydays_s2   <= {{(YDW-YW){1'b0}}, diff_s1}
			* {{(YDW-MW){1'b0}}, dtsr_pkg::DAYS_PER_YEAR};
		leaps_y_s2 <= yzero_s1 ? '0 : dtsr_pkg::leap_count(qyp_s1, c_yp);
		leaps_r_s2 <= rzero_s1 ? '0 : dtsr_pkg::leap_count(qrp_s1, c_rp);
		md_s2      <= dtsr_pkg::days_before_month(month_s1)
			+ {{(MW-1){1'b0}}, leap_adj}
			+ {{(MW-dtsr_pkg::DAY_W){1'b0}}, day_off};
		tod_s2     <= tod_s1;
	end

	// ---- stage 3: total day count ----
	logic [DW-1:0] years_days;

	logic          vld_s3;
	logic [DW-1:0] days_s3;
	logic [TW-1:0] tod_s3;

	// The later year never has fewer leap years below it, so this cannot wrap.
	assign years_days = {{(DW-YDW){1'b0}}, ydays_s2} + {{(DW-LW){1'b0}}, leaps_y_s2}
		- {{(DW-LW){1'b0}}, leaps_r_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		days_s3 <= (gt_s2 ? years_days : '0) + {{(DW-MW){1'b0}}, md_s2};
		tod_s3  <= tod_s2;
	end

	assign beat.vld  = vld_s3;
	assign beat.days = days_s3;
	assign beat.tod  = tod_s3;

endmodule

`default_nettype wire

// ===== design/dtsr_scale.sv =====
// Seconds stage: scales days to seconds, adds time of day and saturates.
`default_nettype none

module dtsr_scale (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dtsr_pkg::days_beat_t            beat,
	output logic                                 done,
	output logic [dtsr_pkg::OUT_W-1:0]           elapsed_seconds
);

	localparam int DW = dtsr_pkg::DAYS_W;
	localparam int SW = dtsr_pkg::SPD_W;
	localparam int PW = dtsr_pkg::PROD_W;
	localparam int TW = dtsr_pkg::TOD_W;
	localparam int OW = dtsr_pkg::OUT_W;

	logic          vld_s4;
	logic [PW-1:0] prod_s4;
	logic [TW-1:0] tod_s4;

	logic [PW:0]   sum;
	logic          vld_s5;
	logic [OW-1:0] elapsed_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= beat.vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= {{SW{1'b0}}, beat.days} * {{DW{1'b0}}, dtsr_pkg::SECS_PER_DAY};
		tod_s4  <= beat.tod;
	end

	assign sum = {1'b0, prod_s4} + {{(PW+1-TW){1'b0}}, tod_s4};

	always_ff @(posedge clk) begin
		if (sum[PW:OW] != '0) begin
			elapsed_s5 <= dtsr_pkg::OUT_MAX;
		end else begin
			elapsed_s5 <= sum[OW-1:0];
		end
	end

	assign done            = vld_s5;
	assign elapsed_seconds = elapsed_s5;

endmodule

`default_nettype wire

// ===== design/date_to_seconds_since_reference.sv =====
// Top level of the calendar date to elapsed seconds converter.
//
// A date (year, month, day, hour, minute, second) is taken on the edge where
// start is high and busy is low. busy stays low, so a new date may be given
// in every cycle. The result, the seconds since 1 January 00:00:00 of the
// reference year, shows on elapsed_seconds with done high for one cycle,
// once the date has passed the register stages below; results leave in
// the order the dates came in, one per date. The receiver has no way to
// hold results back and none is needed: every stage moves on each cycle.
// The five register stages are year differences and reciprocal
// products, leap counts and month offset, day total, the days-by-86400
// multiply, and the final add with saturation at 2^34 - 1.
// The reference year sits in the register at APB word address zero. It
// must be written only while no date is in flight, a rule the block
// leaves to the user. It is sampled as each date enters. An asynchronous
// reset empties the pipeline (done low) and sets the reference year to 1990.
`default_nettype none

module date_to_seconds_since_reference (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [dtsr_pkg::YEAR_W-1:0]       year,
	input  wire logic [dtsr_pkg::MONTH_W-1:0]      month,
	input  wire logic [dtsr_pkg::DAY_W-1:0]        day,
	input  wire logic [dtsr_pkg::HOUR_W-1:0]       hour,
	input  wire logic [dtsr_pkg::MIN_W-1:0]        minute,
	input  wire logic [dtsr_pkg::SEC_W-1:0]        second,
	output logic                                   done,
	output logic [dtsr_pkg::OUT_W-1:0]             elapsed_seconds,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [dtsr_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [dtsr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [dtsr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	logic                        accept;
	logic [dtsr_pkg::YEAR_W-1:0] ref_year;
	dtsr_pkg::days_beat_t        days_beat;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	dtsr_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ref_year (ref_year)
	);

	dtsr_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.year     (year),
		.month    (month),
		.day      (day),
		.hour     (hour),
		.minute   (minute),
		.second   (second),
		.ref_year (ref_year),
		.beat     (days_beat)
	);

	dtsr_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.beat            (days_beat),
		.done            (done),
		.elapsed_seconds (elapsed_seconds)
	);

endmodule

`default_nettype wire

// ===== design/dtsr_checker.sv =====
// Port-level checker for the date to seconds converter, bound to the top level.
`default_nettype none

`include "date_to_seconds_since_reference_assert.svh"

module dtsr_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              busy,
	input  wire logic [dtsr_pkg::YEAR_W-1:0]       year,
	input  wire logic [dtsr_pkg::MONTH_W-1:0]      month,
	input  wire logic [dtsr_pkg::DAY_W-1:0]        day,
	input  wire logic [dtsr_pkg::HOUR_W-1:0]       hour,
	input  wire logic [dtsr_pkg::MIN_W-1:0]        minute,
	input  wire logic [dtsr_pkg::SEC_W-1:0]        second,
	input  wire logic                              done,
	input  wire logic [dtsr_pkg::OUT_W-1:0]        elapsed_seconds
);

	logic accept;
	logic origin_date;

	assign accept = start && !busy;

	// Year zero never lies after the reference, so midnight of its first day is time zero.
	assign origin_date = (year == '0) && (month <= 4'd1) && (day <= 5'd1)
		&& (hour == '0) && (minute == '0) && (second == '0);

	`DTSR_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`DTSR_ASSERT_DELAY(a_result_follows, clk, arst_n, accept, 5, done)
	`DTSR_ASSERT_DELAY(a_no_spurious_result, clk, arst_n, !accept, 5, !done)
	`DTSR_ASSERT_DELAY(a_origin_is_zero, clk, arst_n, accept && origin_date, 5, elapsed_seconds == '0)

endmodule

bind date_to_seconds_since_reference dtsr_checker u_dtsr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.year            (year),
	.month           (month),
	.day             (day),
	.hour            (hour),
	.minute          (minute),
	.second          (second),
	.done            (done),
	.elapsed_seconds (elapsed_seconds)
);

`default_nettype wire

// ===== tb/elapsed_seconds_checker.sv =====
// Checker that predicts elapsed seconds for each accepted date and compares the results.
`default_nettype none

module elapsed_seconds_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              busy,
	input  wire logic [dtsr_pkg::YEAR_W-1:0]       year,
	input  wire logic [dtsr_pkg::MONTH_W-1:0]      month,
	input  wire logic [dtsr_pkg::DAY_W-1:0]        day,
	input  wire logic [dtsr_pkg::HOUR_W-1:0]       hour,
	input  wire logic [dtsr_pkg::MIN_W-1:0]        minute,
	input  wire logic [dtsr_pkg::SEC_W-1:0]        second,
	input  wire logic                              done,
	input  wire logic [dtsr_pkg::OUT_W-1:0]        elapsed_seconds,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [dtsr_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [dtsr_pkg::APB_DATA_W-1:0]   pwdata,
	input  wire logic                              pready,
	output int unsigned                            fail_count,
	output int unsigned                            pending_dates
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 20;
	localparam longint unsigned SAT_SECONDS = (64'd1 << dtsr_pkg::OUT_W) - 64'd1;
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		logic [dtsr_pkg::OUT_W-1:0]   seconds;
		logic [dtsr_pkg::YEAR_W-1:0]  year;
		logic [dtsr_pkg::MONTH_W-1:0] month;
		logic [dtsr_pkg::DAY_W-1:0]   day;
	} expected_date_t;

	logic [dtsr_pkg::YEAR_W-1:0] base_year;
	expected_date_t              expected_dates [$];
	expected_date_t              oldest;
	expected_date_t              fresh;

	function automatic bit leap_year(input longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// Leap years among 0 .. y-1; year zero itself counts as a leap year.
	function automatic longint unsigned leaps_before(input longint unsigned y);
		if (y == 0)
			return 0;
		return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
	endfunction

	function automatic logic [dtsr_pkg::OUT_W-1:0] seconds_since_base(
			input logic [dtsr_pkg::YEAR_W-1:0] y, input logic [dtsr_pkg::MONTH_W-1:0] m,
			input logic [dtsr_pkg::DAY_W-1:0] d, input logic [dtsr_pkg::HOUR_W-1:0] h,
			input logic [dtsr_pkg::MIN_W-1:0] mi, input logic [dtsr_pkg::SEC_W-1:0] s,
			input logic [dtsr_pkg::YEAR_W-1:0] base);
		longint unsigned yv;
		longint unsigned bv;
		longint unsigned days;
		longint unsigned total;
		yv = y;
		bv = base;
		days = 0;
		if (yv > bv)
			days = (yv - bv) * 365 + leaps_before(yv) - leaps_before(bv);
		// Month codes above twelve count the whole year.
		if (m >= 13) begin
			days += leap_year(yv) ? 366 : 365;
		end else begin
			for (int i = 1; i < m; i++)
				days += (i == 2 && leap_year(yv)) ? 29 : MONTH_DAYS[i-1];
		end
		if (d != 0)
			days += longint'(d) - 1;
		total = days * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s);
		if (total > SAT_SECONDS)
			total = SAT_SECONDS;
		return total[dtsr_pkg::OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year = dtsr_pkg::REFERENCE_YEAR_RST;
			expected_dates.delete();
			pending_dates = 0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr == {dtsr_pkg::REG_REFERENCE_YEAR, 2'b00})
				base_year = pwdata[dtsr_pkg::YEAR_W-1:0];
			if (done) begin
				if (expected_dates.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$error("elapsed_seconds: no date pending, actual %0d", elapsed_seconds);
					fail_count++;
				end else begin
					oldest = expected_dates.pop_front();
					if (elapsed_seconds !== oldest.seconds) begin
						if (fail_count < MAX_REPORTS)
							$error("elapsed_seconds (%0d-%0d-%0d): expected %0d, actual %0d",
								oldest.year, oldest.month, oldest.day,
								oldest.seconds, elapsed_seconds);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				fresh.seconds = seconds_since_base(year, month, day, hour, minute, second,
					base_year);
				fresh.year = year;
				fresh.month = month;
				fresh.day = day;
				expected_dates.push_back(fresh);
			end
			pending_dates = expected_dates.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/date_to_seconds_since_reference_test.sv =====
// Top of the date to elapsed seconds testbench: clock, reset, stimulus and verdict.
`default_nettype none

module date_to_seconds_since_reference_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_DATES   = 2000;
	localparam int PHASES         = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam logic [dtsr_pkg::APB_ADDR_W-1:0] BASE_YEAR_ADDR =
		{dtsr_pkg::REG_REFERENCE_YEAR, 2'b00};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic [dtsr_pkg::YEAR_W-1:0]         year = '0;
	logic [dtsr_pkg::MONTH_W-1:0]        month = '0;
	logic [dtsr_pkg::DAY_W-1:0]          day = '0;
	logic [dtsr_pkg::HOUR_W-1:0]         hour = '0;
	logic [dtsr_pkg::MIN_W-1:0]          minute = '0;
	logic [dtsr_pkg::SEC_W-1:0]          second = '0;
	logic                                done;
	logic [dtsr_pkg::OUT_W-1:0]          elapsed_seconds;
	logic                                psel = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite = 1'b0;
	logic [dtsr_pkg::APB_ADDR_W-1:0]     paddr = '0;
	logic [dtsr_pkg::APB_DATA_W-1:0]     pwdata = '0;
	logic [dtsr_pkg::APB_DATA_W-1:0]     prdata;
	logic                                pready;
	int unsigned                         fail_count;
	int unsigned                         pending_dates;
	int unsigned                         idle_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	date_to_seconds_since_reference u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.year            (year),
		.month           (month),
		.day             (day),
		.hour            (hour),
		.minute          (minute),
		.second          (second),
		.done            (done),
		.elapsed_seconds (elapsed_seconds),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	elapsed_seconds_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.year            (year),
		.month           (month),
		.day             (day),
		.hour            (hour),
		.minute          (minute),
		.second          (second),
		.done            (done),
		.elapsed_seconds (elapsed_seconds),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.fail_count      (fail_count),
		.pending_dates   (pending_dates)
	);

	// Any beat on either channel or the register port counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("date_to_seconds_since_reference verification failed");
		$finish;
	end

	task automatic send_date(input logic [dtsr_pkg::YEAR_W-1:0] y,
			input logic [dtsr_pkg::MONTH_W-1:0] m,
			input logic [dtsr_pkg::DAY_W-1:0] d, input logic [dtsr_pkg::HOUR_W-1:0] h,
			input logic [dtsr_pkg::MIN_W-1:0] mi, input logic [dtsr_pkg::SEC_W-1:0] s,
			input int gap);
		start  <= 1'b1;
		year   <= y;
		month  <= m;
		day    <= d;
		hour   <= h;
		minute <= mi;
		second <= s;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Called in the step of the last beat, so start is lowered exactly once here.
	task automatic drain_dates();
		start <= 1'b0;
		@(posedge clk);
		while (pending_dates != 0)
			@(posedge clk);
	endtask

	task automatic write_base_year(input logic [dtsr_pkg::YEAR_W-1:0] y, input bit junk_upper);
		logic [dtsr_pkg::APB_DATA_W-1:0] data;
		data = junk_upper ? $urandom : '0;
		data[dtsr_pkg::YEAR_W-1:0] = y;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BASE_YEAR_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly back-to-back beats, some short gaps and a rare long one.
	function automatic int pick_gap(input bit with_gaps);
		int roll;
		if (!with_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_random_date(input logic [dtsr_pkg::YEAR_W-1:0] base,
			input bit with_gaps);
		int y;
		if ($urandom_range(0, 9) < 7) begin
			// Realistic dates around the base year, a few before it.
			y = int'(base) + int'($urandom_range(0, 650)) - 50;
			if (y < 0)
				y = 0;
			if (y > 4095)
				y = 4095;
			send_date(y[dtsr_pkg::YEAR_W-1:0],
				dtsr_pkg::MONTH_W'($urandom_range(1, 12)),
				dtsr_pkg::DAY_W'($urandom_range(1, 31)),
				dtsr_pkg::HOUR_W'($urandom_range(0, 23)),
				dtsr_pkg::MIN_W'($urandom_range(0, 59)),
				dtsr_pkg::SEC_W'($urandom_range(0, 59)),
				pick_gap(with_gaps));
		end else begin
			send_date(dtsr_pkg::YEAR_W'($urandom), dtsr_pkg::MONTH_W'($urandom),
				dtsr_pkg::DAY_W'($urandom), dtsr_pkg::HOUR_W'($urandom),
				dtsr_pkg::MIN_W'($urandom), dtsr_pkg::SEC_W'($urandom),
				pick_gap(with_gaps));
		end
	endtask

	initial begin
		logic [dtsr_pkg::YEAR_W-1:0] base;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed dates against the reset base year.
		send_date(12'd1990, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd1991, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd1989, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1);
		send_date(12'd1900, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 0);
		send_date(12'd1996, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30, 0);
		send_date(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 2);
		send_date(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd2400, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 0);
		send_date(12'd2024, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd2023, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 1);
		send_date(12'd2024, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd2024, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 0);
		send_date(12'd2010, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63, 0);
		send_date(12'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 3);
		send_date(12'd2534, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd2534, 4'd7, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 0);
		drain_dates();

		// Year zero as the base: it is itself a leap year.
		write_base_year(12'd0, 1'b0);
		send_date(12'd0, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 0);
		send_date(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 0);
		drain_dates();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: base = 12'd4095;
				1: base = 12'd1900;
				2: base = 12'd2411;
				3: base = 12'd0;
				default: base = p[0] ? dtsr_pkg::YEAR_W'($urandom_range(0, 4095))
					: dtsr_pkg::YEAR_W'($urandom_range(1900, 2411));
			endcase
			write_base_year(base, p[0]);
			for (int i = 0; i < RANDOM_DATES / PHASES; i++)
				send_random_date(base, (p % 3) != 0);
			drain_dates();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("date_to_seconds_since_reference verification clean");
		else
			$display("date_to_seconds_since_reference verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/dtsr_pkg.sv
design/dtsr_apb.sv
design/dtsr_days.sv
design/dtsr_scale.sv
design/date_to_seconds_since_reference.sv
design/dtsr_checker.sv
tb/elapsed_seconds_checker.sv
tb/date_to_seconds_since_reference_test.sv
